/* rtl/core/gibs_pkg.sv */
// Package for the interval bound search: item types, request codes, control structs.
package gibs_pkg;

  localparam int IDX_W = 13;
  localparam int POS_W = 32;
  localparam int REQ_W = 2;
  localparam int DEFAULT_MAX_POSITIONS = 4096;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [IDX_W-1:0]        load_index;
    logic signed [POS_W-1:0] load_value;
    logic signed [POS_W-1:0] query_start;
    logic signed [POS_W-1:0] query_stop;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] left_bound;
    logic [IDX_W-1:0] right_bound;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_BEGIN,
    OP_QSTART,
    OP_RD_LO,
    OP_LO_CHK,
    OP_GAL_STEP,
    OP_GAL_CHK,
    OP_BIS_STEP,
    OP_BIS_CHK
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   phase;   // 0: left bound search, 1: right bound search
  } dp_cmd_t;

  typedef struct packed {
    logic gal_end;   // next gallop probe reaches the count
    logic go_hi;     // probed key lies at or past the bound, so the search moves toward low
    logic bis_end;   // high is at most one above low
  } dp_status_t;

endpackage

/* rtl/core/galloping_interval_bound_search_top.sv */
// Top level of the galloping interval bound search block.
//
// Usage: drive in_item and raise start; the item is taken at a rising edge
// with start high and busy low. req_type picks the action:
//   load  - write load_value into the position store at load_index (1-based),
//   begin - reset the search window to low = 1, high = count,
//   query - search the store for the bounds of [query_start, query_stop].
// Load and begin items never raise busy. A query raises busy and walks a
// gallop and a bisection for each bound; every store probe puts an address
// into the store and compares the registered read data in the next cycle.
// Before the probes, the window low is read and checked once per query; the
// last step of each bisection and any gallop step that runs into the count
// compare no read data. All store probes go through the one read port.
// The result appears on out_item with out_valid high for exactly one cycle,
// the first cycle with busy low again; the receiver cannot stall it, and a
// new item may be started in that same cycle.
// cfg_data writes the position count whenever cfg_valid is high; write it
// only while no query is running. Reset sets the count to 1 and the window to
// [1, 1]; the store holds nothing defined until loaded, so no clearing pass.
module galloping_interval_bound_search_top #(
  parameter int MAX_POSITIONS = gibs_pkg::DEFAULT_MAX_POSITIONS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  gibs_pkg::in_item_t          in_item,
  output logic                        out_valid,
  output gibs_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gibs_pkg::IDX_W-1:0]  cfg_data
);

  gibs_pkg::dp_cmd_t    cmd;
  gibs_pkg::dp_status_t status;

  // Accept register writes at once; they are to be issued only while idle, which this block does not enforce.
  assign cfg_ready = 1'b1;

  gibs_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_item.req_type),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  gibs_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .status   (status),
    .out_item (out_item)
  );

endmodule

/* rtl/core/gibs_controller.sv */
// Sequencer for the interval bound search: steps the datapath through each query.
module gibs_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gibs_pkg::REQ_W-1:0]    req_type,
  input  gibs_pkg::dp_status_t          status,
  output gibs_pkg::dp_cmd_t             cmd,
  output logic                          busy,
  output logic                          out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_LO_CHK,
    S_GAL_STEP,
    S_GAL_CHK,
    S_BIS_STEP,
    S_BIS_CHK
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = 1'b0;
    cmd.op        = gibs_pkg::OP_IDLE;
    cmd.phase     = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (req_type)
            gibs_pkg::REQ_LOAD:  cmd.op = gibs_pkg::OP_LOAD;
            gibs_pkg::REQ_BEGIN: cmd.op = gibs_pkg::OP_BEGIN;
            gibs_pkg::REQ_QUERY: begin
              cmd.op    = gibs_pkg::OP_QSTART;
              state_nxt = S_RD_LO;
              phase_nxt = 1'b0;
            end
            default: cmd.op = gibs_pkg::OP_IDLE;
          endcase
        end
      end
      S_RD_LO: begin
        cmd.op    = gibs_pkg::OP_RD_LO;
        state_nxt = S_LO_CHK;
      end
      S_LO_CHK: begin
        cmd.op    = gibs_pkg::OP_LO_CHK;
        state_nxt = S_GAL_STEP;
      end
      S_GAL_STEP: begin
        cmd.op    = gibs_pkg::OP_GAL_STEP;
        state_nxt = status.gal_end ? S_BIS_STEP : S_GAL_CHK;
      end
      S_GAL_CHK: begin
        cmd.op    = gibs_pkg::OP_GAL_CHK;
        state_nxt = status.go_hi ? S_BIS_STEP : S_GAL_STEP;
      end
      S_BIS_STEP: begin
        cmd.op = gibs_pkg::OP_BIS_STEP;
        if (!status.bis_end) begin
          state_nxt = S_BIS_CHK;
        end else if (!phase_r) begin
          state_nxt = S_GAL_STEP;
          phase_nxt = 1'b1;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      S_BIS_CHK: begin
        cmd.op    = gibs_pkg::OP_BIS_CHK;
        state_nxt = S_BIS_STEP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/gibs_datapath.sv */
// Datapath for the interval bound search: position store, window and search registers.
module gibs_datapath #(
  parameter int MAX_POSITIONS = gibs_pkg::DEFAULT_MAX_POSITIONS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gibs_pkg::dp_cmd_t             cmd,
  input  gibs_pkg::in_item_t            in_item,
  input  logic                          cfg_we,
  input  logic [gibs_pkg::IDX_W-1:0]    cfg_data,
  output gibs_pkg::dp_status_t          status,
  output gibs_pkg::out_item_t           out_item
);

  localparam int AW = $clog2(MAX_POSITIONS);
  localparam int IW = $clog2(MAX_POSITIONS + 1);
  localparam int SW = IW + 2;
  localparam logic [IW-1:0] ONE  = IW'(1);
  localparam logic [IW-1:0] MAXV = IW'(MAX_POSITIONS);

  logic [gibs_pkg::POS_W-1:0] mem [MAX_POSITIONS];
  logic [gibs_pkg::POS_W-1:0] rdata_r;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic                       wr_en;

  logic [gibs_pkg::IDX_W-1:0] count_r;
  logic [IW-1:0]              win_lo_r, win_hi_r;
  logic [IW-1:0]              lo_r, hi_r, probe_r, left_r;
  logic [IW:0]                jump_r;
  logic signed [gibs_pkg::POS_W-1:0] s_r, e_r;
  gibs_pkg::out_item_t        out_r;

  logic [IW-1:0] n;
  logic [IW-1:0] lo_c, hi_c;
  logic [SW-1:0] gal_sum;
  logic [IW:0]   bis_sum;
  logic [IW-1:0] probe;

  // Clamp the count register to [1, MAX_POSITIONS].
  always_comb begin
    if (count_r == '0) begin
      n = ONE;
    end else if (32'(count_r) > 32'(MAX_POSITIONS)) begin
      n = MAXV;
    end else begin
      n = IW'(count_r);
    end
  end

  assign lo_c    = (win_lo_r == '0 || win_lo_r > n) ? ONE : win_lo_r;
  assign hi_c    = (win_hi_r == '0 || win_hi_r > n) ? n : win_hi_r;
  assign gal_sum = SW'(hi_r) + SW'(jump_r);
  assign bis_sum = (IW+1)'(hi_r) + (IW+1)'(lo_r);
  assign probe   = IW'(bis_sum >> 1);

  assign status.gal_end = (gal_sum >= SW'(n));
  assign status.bis_end = !((IW+1)'(hi_r) > (IW+1)'(lo_r) + (IW+1)'(1));
  assign status.go_hi   = cmd.phase ? !($signed(rdata_r) < e_r) : (s_r < $signed(rdata_r));

  assign wr_en   = (cmd.op == gibs_pkg::OP_LOAD) && (in_item.load_index != '0) &&
                   (32'(in_item.load_index) <= 32'(MAX_POSITIONS));
  assign wr_addr = AW'(in_item.load_index - gibs_pkg::IDX_W'(1));

  always_comb begin
    unique case (cmd.op)
      gibs_pkg::OP_RD_LO:    rd_addr = AW'(lo_r - ONE);
      gibs_pkg::OP_GAL_STEP: rd_addr = AW'(gal_sum - SW'(1));
      gibs_pkg::OP_BIS_STEP: rd_addr = AW'(probe - ONE);
      default:               rd_addr = AW'(lo_r - ONE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_item.load_value;
    end
    rdata_r <= mem[rd_addr];
  end

  // Count and search window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= gibs_pkg::IDX_W'(1);
      win_lo_r <= ONE;
      win_hi_r <= ONE;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_data;
      end
      if (cmd.op == gibs_pkg::OP_BEGIN) begin
        win_lo_r <= ONE;
        win_hi_r <= n;
      end else if (cmd.op == gibs_pkg::OP_BIS_STEP && status.bis_end && cmd.phase) begin
        win_lo_r <= left_r;
        win_hi_r <= hi_r;
      end
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gibs_pkg::OP_QSTART: begin
        s_r  <= in_item.query_start;
        e_r  <= in_item.query_stop;
        lo_r <= lo_c;
        hi_r <= hi_c;
      end
      gibs_pkg::OP_LO_CHK: begin
        if (status.go_hi) begin
          lo_r <= ONE;
        end
        jump_r <= (IW+1)'(1);
      end
      gibs_pkg::OP_GAL_STEP: begin
        hi_r <= status.gal_end ? n : IW'(gal_sum);
      end
      gibs_pkg::OP_GAL_CHK: begin
        if (!status.go_hi) begin
          lo_r   <= hi_r;
          jump_r <= {jump_r[IW-1:0], 1'b0};
        end
      end
      gibs_pkg::OP_BIS_STEP: begin
        if (!status.bis_end) begin
          probe_r <= probe;
        end else if (!cmd.phase) begin
          left_r <= lo_r;
          jump_r <= (IW+1)'(1);
        end else begin
          out_r.left_bound  <= gibs_pkg::IDX_W'(left_r);
          out_r.right_bound <= gibs_pkg::IDX_W'(hi_r);
        end
      end
      gibs_pkg::OP_BIS_CHK: begin
        if (status.go_hi) begin
          hi_r <= probe_r;
        end else begin
          lo_r <= probe_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_item = out_r;

endmodule
